// ===== hw/rtl/ubds_pkg.sv =====
`timescale 1ns / 1ps
package ubds_pkg;
	localparam int FREQ_W = 31;
	localparam int BAUD_W = 24;
	localparam int DIV_OUT_W = 13;
	localparam int OSR_OUT_W = 6;
	localparam int RATIO_W = 7;
	localparam int DSEL_W = 16;
	localparam int ERR_W = 31;
	localparam logic [FREQ_W-1:0] FREQ_RESET = 31'd48000000;
	localparam int OSR_FIRST_DEF = 4;
	localparam int OSR_LAST_DEF = 32;
	localparam int DIVISOR_LIMIT_DEF = 8191;
	localparam int DIV_BPS = 4;
	localparam int FOLD_PER_ST = 4;
endpackage

// ===== hw/rtl/ubds_ifs.sv =====
`timescale 1ns / 1ps
interface ubds_cfg_if;
	logic valid;
	logic ready;
	logic [ubds_pkg::FREQ_W-1:0] clock_frequency;
	modport source(output valid, clock_frequency, input ready);
	modport sink(input valid, clock_frequency, output ready);
endinterface

interface ubds_req_if;
	logic valid;
	logic ready;
	logic [ubds_pkg::BAUD_W-1:0] baud_rate;
	modport source(output valid, baud_rate, input ready);
	modport sink(input valid, baud_rate, output ready);
endinterface

interface ubds_rsp_if;
	logic valid;
	logic ready;
	logic found;
	logic [ubds_pkg::DIV_OUT_W-1:0] baud_divisor;
	logic [ubds_pkg::OSR_OUT_W-1:0] oversample_ratio;
	modport source(output valid, found, baud_divisor, oversample_ratio, input ready);
	modport sink(input valid, found, baud_divisor, oversample_ratio, output ready);
endinterface

// ===== hw/rtl/uart_baud_divisor_search_top.sv =====
`timescale 1ns / 1ps
// channel | dir | word
// cfg     | in  | clock_frequency, always ready
// req     | in  | baud_rate
// rsp     | out | found, baud_divisor, oversample_ratio
//
// one word per cycle in and out unless rsp stalls; stages: divider, multiply, floor, errors, fold
// the quotient divider retires four bits per stage, the ratio scan folds four ratios per stage
// arst_n clears the valid bits and loads clock_frequency with 48000000
// each stage holds only while it is full and the one after it holds, so bubbles close up
module uart_baud_divisor_search_top #(
	parameter int OSR_FIRST = ubds_pkg::OSR_FIRST_DEF,
	parameter int OSR_LAST = ubds_pkg::OSR_LAST_DEF,
	parameter int DIVISOR_LIMIT = ubds_pkg::DIVISOR_LIMIT_DEF
) (
	input logic clk,
	input logic arst_n,
	ubds_cfg_if.sink cfg,
	ubds_req_if.sink req,
	ubds_rsp_if.source rsp
);
	localparam int QW = ubds_pkg::FREQ_W;
	localparam int BW = ubds_pkg::BAUD_W;
	localparam int RW = ubds_pkg::RATIO_W;
	localparam int EW = ubds_pkg::ERR_W;
	localparam int DW = ubds_pkg::DSEL_W;
	localparam int KSH = QW + RW;
	localparam int MW = QW + KSH;
	localparam int NR = OSR_LAST - OSR_FIRST + 1;
	localparam int FPS = ubds_pkg::FOLD_PER_ST;
	localparam int FOLD_ST = (NR + FPS - 1) / FPS;
	localparam int NPAD = FOLD_ST * FPS;
	localparam int BPS = ubds_pkg::DIV_BPS;
	localparam int DIV_ST = (QW + BPS - 1) / BPS;
	localparam int NST = DIV_ST + 3 + FOLD_ST;
	localparam int L1 = DIV_ST;
	localparam int L2 = DIV_ST + 1;
	localparam int L3 = DIV_ST + 2;

	typedef struct packed {
		logic [EW-1:0] best;
		logic [DW-1:0] div;
		logic [RW-1:0] ratio;
		logic found;
		logic zero;
	} sel_t;

	logic [QW-1:0] clk_freq_q;
	logic [NST-1:0] v_q;
	logic [NST-1:0] en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clk_freq_q <= ubds_pkg::FREQ_RESET;
		end else if (cfg.valid) begin
			clk_freq_q <= cfg.clock_frequency;
		end
	end
	assign cfg.ready = 1'b1;

	always_comb begin
		en[NST-1] = !v_q[NST-1] || rsp.ready;
		for (int k = NST - 2; k >= 0; k--) begin
			en[k] = !v_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0]) begin
				v_q[0] <= req.valid;
			end
			for (int k = 1; k < NST; k++) begin
				if (en[k]) begin
					v_q[k] <= v_q[k-1];
				end
			end
		end
	end
	assign req.ready = en[0];

	// quotient of clock over baud, restoring
	logic [QW-1:0] dv_f_s [DIV_ST];
	logic [QW-1:0] dv_q_s [DIV_ST];
	logic [BW-1:0] dv_b_s [DIV_ST];
	logic [BW-1:0] dv_r_s [DIV_ST];
	logic dv_z_s [DIV_ST];

	genvar k, i, j;
	for (k = 0; k < DIV_ST; k++) begin : g_div
		logic [QW-1:0] f_in, q_in, q_nx;
		logic [BW-1:0] b_in, r_in, r_nx;
		logic z_in;
		if (k == 0) begin : g_src
			assign f_in = clk_freq_q;
			assign q_in = '0;
			assign b_in = req.baud_rate;
			assign r_in = '0;
			assign z_in = (req.baud_rate == '0);
		end else begin : g_src
			assign f_in = dv_f_s[k-1];
			assign q_in = dv_q_s[k-1];
			assign b_in = dv_b_s[k-1];
			assign r_in = dv_r_s[k-1];
			assign z_in = dv_z_s[k-1];
		end
		always_comb begin
			logic [BW:0] t;
			int idx;
			q_nx = q_in;
			r_nx = r_in;
			for (int s = 0; s < BPS; s++) begin
				idx = QW - 1 - (k * BPS + s);
				if (idx >= 0) begin
					t = {r_nx, f_in[idx]};
					if (t >= {1'b0, b_in}) begin
						t = t - {1'b0, b_in};
						q_nx[idx] = 1'b1;
					end
					r_nx = t[BW-1:0];
				end
			end
		end
		always_ff @(posedge clk) begin
			if (en[k]) begin
				dv_f_s[k] <= f_in;
				dv_q_s[k] <= q_nx;
				dv_b_s[k] <= b_in;
				dv_r_s[k] <= r_nx;
				dv_z_s[k] <= z_in;
			end
		end
	end

	logic [QW-1:0] q_s1;
	logic [BW-1:0] rem_s1, b_s1, rem_s2, b_s2;
	logic z_s1, z_s2;

	always_ff @(posedge clk) begin
		if (en[L1]) begin
			q_s1 <= dv_q_s[DIV_ST-1];
			rem_s1 <= dv_r_s[DIV_ST-1];
			b_s1 <= dv_b_s[DIV_ST-1];
			z_s1 <= dv_z_s[DIV_ST-1];
		end
		if (en[L2]) begin
			rem_s2 <= rem_s1;
			b_s2 <= b_s1;
			z_s2 <= z_s1;
		end
	end

	// one lane per ratio: floor by reciprocal, then both errors
	logic [MW-1:0] mul_s1 [NR];
	logic [QW-1:0] d_s2 [NR];
	logic [RW-1:0] mod_s2 [NR];
	logic [EW-1:0] ed_nx [NR];
	logic [EW-1:0] fl_ed_s [FOLD_ST][NPAD];
	logic [EW-1:0] fl_eu_s [FOLD_ST][NPAD];
	logic [DW-1:0] fl_dv_s [FOLD_ST][NPAD];
	logic fl_okd_s [FOLD_ST][NPAD];
	logic fl_oku_s [FOLD_ST][NPAD];
	sel_t sel_s [FOLD_ST+1];

	for (i = 0; i < NPAD; i++) begin : g_lane
		if (i < NR) begin : g_real
			localparam int R = OSR_FIRST + i + 1;
			localparam logic [KSH-1:0] MUL =
				KSH'(((64'd1 << KSH) + 64'(R) - 64'd1) / 64'(R));
			localparam logic [RW-1:0] RV = RW'(R);
			logic [QW+RW-1:0] dr;
			logic [QW-1:0] d_nx;
			logic [EW-1:0] eu_nx;
			assign d_nx = mul_s1[i][KSH +: QW];
			assign dr = (QW+RW)'(d_nx) * (QW+RW)'(RV);
			assign ed_nx[i] = EW'(rem_s2) + EW'(b_s2) * EW'(mod_s2[i]);
			assign eu_nx = EW'(b_s2) * EW'(RV) - ed_nx[i];
			always_ff @(posedge clk) begin
				if (en[L1]) begin
					mul_s1[i] <= MW'(dv_q_s[DIV_ST-1]) * MW'(MUL);
				end
				if (en[L2]) begin
					d_s2[i] <= d_nx;
					mod_s2[i] <= RW'(q_s1 - dr[QW-1:0]);
				end
				if (en[L3]) begin
					fl_ed_s[0][i] <= ed_nx[i];
					fl_eu_s[0][i] <= eu_nx;
					fl_dv_s[0][i] <= DW'(d_s2[i]);
					fl_okd_s[0][i] <= (d_s2[i] > QW'(1)) && (d_s2[i] < QW'(DIVISOR_LIMIT));
					fl_oku_s[0][i] <= (d_s2[i] != '0) && (d_s2[i] < QW'(DIVISOR_LIMIT - 1));
				end
			end
		end else begin : g_pad
			always_ff @(posedge clk) begin
				if (en[L3]) begin
					fl_ed_s[0][i] <= '0;
					fl_eu_s[0][i] <= '0;
					fl_dv_s[0][i] <= '0;
					fl_okd_s[0][i] <= 1'b0;
					fl_oku_s[0][i] <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[L3]) begin
			sel_s[0] <= '{best: ed_nx[0], div: '0, ratio: '0, found: 1'b0, zero: z_s2};
		end
	end

	// ratios visited in increasing order, four per stage
	for (j = 1; j <= FOLD_ST; j++) begin : g_fold
		sel_t nx;
		always_comb begin
			nx = sel_s[j-1];
			for (int l = 0; l < FPS; l++) begin
				if (fl_okd_s[j-1][(j-1)*FPS+l] && fl_ed_s[j-1][(j-1)*FPS+l] <= nx.best &&
					!(fl_ed_s[j-1][(j-1)*FPS+l] == nx.best &&
					fl_dv_s[j-1][(j-1)*FPS+l] < DW'(OSR_FIRST + (j-1)*FPS + l))) begin
					nx.best = fl_ed_s[j-1][(j-1)*FPS+l];
					nx.div = fl_dv_s[j-1][(j-1)*FPS+l];
					nx.ratio = RW'(OSR_FIRST + (j-1)*FPS + l);
					nx.found = 1'b1;
				end
				if (fl_oku_s[j-1][(j-1)*FPS+l] && fl_eu_s[j-1][(j-1)*FPS+l] < nx.best &&
					nx.best != '0) begin
					nx.best = fl_eu_s[j-1][(j-1)*FPS+l];
					nx.div = fl_dv_s[j-1][(j-1)*FPS+l] + DW'(1);
					nx.ratio = RW'(OSR_FIRST + (j-1)*FPS + l);
					nx.found = 1'b1;
				end
			end
		end
		always_ff @(posedge clk) begin
			if (en[L3+j]) begin
				sel_s[j] <= nx;
			end
		end
		if (j < FOLD_ST) begin : g_carry
			always_ff @(posedge clk) begin
				if (en[L3+j]) begin
					for (int n = 0; n < NPAD; n++) begin
						fl_ed_s[j][n] <= fl_ed_s[j-1][n];
						fl_eu_s[j][n] <= fl_eu_s[j-1][n];
						fl_dv_s[j][n] <= fl_dv_s[j-1][n];
						fl_okd_s[j][n] <= fl_okd_s[j-1][n];
						fl_oku_s[j][n] <= fl_oku_s[j-1][n];
					end
				end
			end
		end
	end

	sel_t fin;
	assign fin = sel_s[FOLD_ST];
	assign rsp.valid = v_q[NST-1];
	assign rsp.found = fin.found && !fin.zero;
	assign rsp.baud_divisor = rsp.found ? fin.div[ubds_pkg::DIV_OUT_W-1:0] : '0;
	assign rsp.oversample_ratio = rsp.found ? fin.ratio[ubds_pkg::OSR_OUT_W-1:0] : '0;

	a_div_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_q[NST-1] && rsp.found |-> fin.div > DW'(1) && fin.div < DW'(DIVISOR_LIMIT))
		else $error("chosen divisor out of range");
	a_ratio_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_q[NST-1] && rsp.found |-> fin.ratio >= RW'(OSR_FIRST) && fin.ratio <= RW'(OSR_LAST))
		else $error("chosen ratio out of range");
	a_zero_baud: assert property (@(posedge clk) disable iff (!arst_n)
		v_q[NST-1] && fin.zero |-> !rsp.found && rsp.baud_divisor == '0)
		else $error("zero baud word reported as found");
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> v_q[0])
		else $error("accepted word not held in first stage");
endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
	typedef struct packed {
		logic found;
		logic [ubds_pkg::DIV_OUT_W-1:0] baud_divisor;
		logic [ubds_pkg::OSR_OUT_W-1:0] oversample_ratio;
	} search_word_t;

	typedef struct {
		logic [ubds_pkg::BAUD_W-1:0] baud;
		bit known;
		search_word_t want;
	} baud_row_t;

	localparam int IDLE_LIMIT = 4000;
	localparam int SETTLE = 30;

	logic clk = 0;
	logic arst_n = 0;
	ubds_cfg_if cfg();
	ubds_req_if req();
	ubds_rsp_if rsp();

	uart_baud_divisor_search_top dut (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .req(req), .rsp(rsp)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	logic [ubds_pkg::FREQ_W-1:0] model_clock = ubds_pkg::FREQ_RESET;
	search_word_t pending_words[$];
	int errors = 0;
	int words_in = 0;
	int words_out = 0;
	int found_count = 0;
	int idle_cycles = 0;
	int send_gap_pct = 0;
	int stall_pct = 0;

	function automatic search_word_t search_divisor(logic [ubds_pkg::BAUD_W-1:0] baud,
			logic [ubds_pkg::FREQ_W-1:0] clock);
		longint f, b, q, d, r, best, err;
		search_word_t res;
		res = '0;
		f = longint'(clock);
		b = longint'(baud);
		if (b == 0)
			return res;
		q = f / b;
		best = f - b * (q / (ubds_pkg::OSR_FIRST_DEF + 1)) * (ubds_pkg::OSR_FIRST_DEF + 1);
		for (int osr = ubds_pkg::OSR_FIRST_DEF; osr <= ubds_pkg::OSR_LAST_DEF; osr++) begin
			r = osr + 1;
			d = q / r;
			err = f - b * d * r;
			if (err <= best && best >= 0 && d > 1 && d < ubds_pkg::DIVISOR_LIMIT_DEF &&
					!(err == best && d < osr)) begin
				best = err;
				res = '{1'b1, d[ubds_pkg::DIV_OUT_W-1:0], osr[ubds_pkg::OSR_OUT_W-1:0]};
			end
			d = q / r + 1;
			err = b * d * r - f;
			if (err < best && best > 0 && d > 1 && d < ubds_pkg::DIVISOR_LIMIT_DEF) begin
				best = err;
				res = '{1'b1, d[ubds_pkg::DIV_OUT_W-1:0], osr[ubds_pkg::OSR_OUT_W-1:0]};
			end
		end
		return res;
	endfunction

	task automatic report(string what, search_word_t got, search_word_t want);
		errors++;
		$display("mismatch %s: got %0d/%0d/%0d want %0d/%0d/%0d at %0t", what,
			got.found, got.baud_divisor, got.oversample_ratio,
			want.found, want.baud_divisor, want.oversample_ratio, $realtime);
	endtask

	// response checker
	always @(posedge clk) begin
		search_word_t got, want;
		if (arst_n && rsp.valid && rsp.ready) begin
			got = '{rsp.found, rsp.baud_divisor, rsp.oversample_ratio};
			words_out++;
			if (pending_words.size() == 0) begin
				report("unexpected word", got, '0);
			end else begin
				want = pending_words.pop_front();
				if (got.found !== want.found)
					report("found", got, want);
				else if (got.baud_divisor !== want.baud_divisor)
					report("baud_divisor", got, want);
				else if (got.oversample_ratio !== want.oversample_ratio)
					report("oversample_ratio", got, want);
				if (want.found)
					found_count++;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n)
			rsp.ready <= 1'b0;
		else
			rsp.ready <= ($urandom_range(99) >= stall_pct);
	end

	// watchdog
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
			$display("testbench: FAIL");
			$finish;
		end
	end

	task automatic send_baud(logic [ubds_pkg::BAUD_W-1:0] baud, bit known, search_word_t want);
		search_word_t predicted;
		if ($urandom_range(99) < send_gap_pct) begin
			req.valid <= 1'b0;
			while ($urandom_range(99) < send_gap_pct)
				@(posedge clk);
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.baud_rate <= baud;
		do @(posedge clk); while (!req.ready);
		predicted = search_divisor(baud, model_clock);
		if (known && predicted != want)
			report("predictor vs table", predicted, want);
		pending_words.push_back(known ? want : predicted);
		words_in++;
	endtask

	task automatic drain;
		req.valid <= 1'b0;
		@(posedge clk);
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_clock(logic [ubds_pkg::FREQ_W-1:0] value);
		drain();
		cfg.valid <= 1'b1;
		cfg.clock_frequency <= value;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		model_clock = value;
	endtask

	function automatic logic [ubds_pkg::BAUD_W-1:0] pick_baud();
		longint t, b;
		if ($urandom_range(3) == 0)
			return ubds_pkg::BAUD_W'($urandom_range(32'hFFFFFF, 1));
		t = $urandom_range(300000, 2);
		b = longint'(model_clock) / t;
		if (b < 1)
			b = 1;
		if (b > 32'hFFFFFF)
			b = 32'hFFFFFF;
		return ubds_pkg::BAUD_W'(b);
	endfunction

	baud_row_t directed[] = '{
		'{24'd0, 1'b1, '0},
		'{24'hFFFFFF, 1'b1, '0},
		'{24'd1, 1'b1, '0},
		'{24'd9600, 1'b0, '0},
		'{24'd115200, 1'b0, '0},
		'{24'd921600, 1'b0, '0},
		'{24'd1000000, 1'b0, '0},
		'{24'd3000000, 1'b0, '0},
		'{24'd12000000, 1'b0, '0},
		'{24'd300, 1'b0, '0},
		'{24'd2400, 1'b0, '0},
		'{24'd57600, 1'b0, '0},
		'{24'd1500000, 1'b0, '0},
		'{24'h800000, 1'b0, '0},
		'{24'h555555, 1'b0, '0},
		'{24'hAAAAAA, 1'b0, '0}
	};

	logic [ubds_pkg::FREQ_W-1:0] clock_plan[] = '{
		31'h7FFFFFFF, 31'd1, 31'd100000000, 31'd12000000, 31'd0, ubds_pkg::FREQ_RESET
	};

	initial begin
		logic [ubds_pkg::FREQ_W-1:0] clock;
		cfg.valid = 1'b0;
		cfg.clock_frequency = '0;
		req.valid = 1'b0;
		req.baud_rate = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_baud(directed[i].baud, directed[i].known, directed[i].want);

		foreach (clock_plan[s]) begin
			clock = clock_plan[s];
			if (clock == 0)
				clock = ubds_pkg::FREQ_W'($urandom_range(32'h7FFFFFFF, 1));
			write_clock(clock);
			send_baud(24'd1, 1'b0, '0);
			send_baud(24'hFFFFFF, 1'b0, '0);
			for (int m = 0; m < 4; m++) begin
				send_gap_pct = (m == 1) ? 78 : (m == 3) ? 8 : 0;
				stall_pct = (m == 2) ? 78 : (m == 3) ? 8 : 0;
				for (int k = 0; k < 42; k++) begin
					if (s == 2 && m == 0 && k == 21)
						drain();
					send_baud(pick_baud(), 1'b0, '0);
				end
			end
		end
		send_gap_pct = 0;
		stall_pct = 0;
		drain();

		$display("sent %0d baud requests over %0d clock settings, %0d words back, %0d found",
			words_in, clock_plan.size() + 1, words_out, found_count);
		if (errors == 0 && pending_words.size() == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end
endmodule

// ===== uart_baud_divisor_search_top.f =====
hw/rtl/ubds_pkg.sv
hw/rtl/ubds_ifs.sv
hw/rtl/uart_baud_divisor_search_top.sv
dv/testbench.sv
